### rtl/direction_to_pose_matrix_defines.svh
`ifndef DIRECTION_TO_POSE_MATRIX_DEFINES_SVH
`define DIRECTION_TO_POSE_MATRIX_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define DTPM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset
`define DTPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dtpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dtpm_pkg;

	localparam int COORD_W   = 32;
	localparam int AXIS_W    = 32;
	localparam int LEN_W     = 31;
	localparam int Q_W       = 31;
	localparam int SQ_W      = 64;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 31;
	localparam int LANES     = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [AXIS_W-1:0]  axis_t;

	localparam axis_t ONE_Q30 = axis_t'(64'sd1 << 30);

	typedef struct packed {
		coord_t tip_x;
		coord_t tip_y;
		coord_t tip_z;
		coord_t aux_x;
		coord_t aux_y;
		coord_t aux_z;
	} in_item_t;

	typedef struct packed {
		axis_t  first_axis_x;
		axis_t  first_axis_y;
		axis_t  first_axis_z;
		axis_t  second_axis_x;
		axis_t  second_axis_y;
		axis_t  second_axis_z;
		axis_t  normal_x;
		axis_t  normal_y;
		axis_t  normal_z;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
	} out_item_t;

	// Side data that rides along the cell chains
	typedef struct packed {
		coord_t            tip_x;
		coord_t            tip_y;
		coord_t            tip_z;
		axis_t             nx;
		axis_t             ny;
		axis_t             nz;
		logic [LANES-1:0]  neg;
		logic              flag;
	} ctx_t;

	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] r;
		logic [SQ_W-1:0] b;
		ctx_t            ctx;
	} sq_t;

	typedef struct packed {
		logic [LEN_W-1:0]            len;
		logic [LANES-1:0][LEN_W-1:0] rem;
		logic [LANES-1:0][Q_W-1:0]   num;
		logic [LANES-1:0][Q_W-1:0]   q;
		ctx_t                        ctx;
	} dv_t;

endpackage
`default_nettype wire

### rtl/dtpm_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dtpm_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          up_valid,
	input  wire dtpm_pkg::sq_t up_data,
	output logic               dn_valid,
	output dtpm_pkg::sq_t      dn_data
);

	dtpm_pkg::sq_t           nxt;
	logic [dtpm_pkg::SQ_W-1:0] trial;
	logic                    valid_q;
	dtpm_pkg::sq_t           data_q;

	// One result bit per cell: subtract r + b when it fits
	always_comb begin
		nxt   = up_data;
		trial = up_data.r + up_data.b;
		if (up_data.v >= trial) begin
			nxt.v = up_data.v - trial;
			nxt.r = (up_data.r >> 1) + up_data.b;
		end else begin
			nxt.r = up_data.r >> 1;
		end
		nxt.b = up_data.b >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

### rtl/dtpm_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dtpm_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          up_valid,
	input  wire dtpm_pkg::dv_t up_data,
	output logic               dn_valid,
	output dtpm_pkg::dv_t      dn_data
);

	dtpm_pkg::dv_t            nxt;
	logic [dtpm_pkg::LEN_W:0] sh;
	logic                     valid_q;
	dtpm_pkg::dv_t            data_q;

	// Restoring divide, one quotient bit per lane per cell
	always_comb begin
		nxt = up_data;
		sh  = '0;
		for (int k = 0; k < dtpm_pkg::LANES; k++) begin
			sh = {up_data.rem[k], up_data.num[k][dtpm_pkg::Q_W-1]};
			if (sh >= {1'b0, up_data.len}) begin
				nxt.rem[k] = dtpm_pkg::LEN_W'(sh - {1'b0, up_data.len});
				nxt.q[k]   = {up_data.q[k][dtpm_pkg::Q_W-2:0], 1'b1};
			end else begin
				nxt.rem[k] = sh[dtpm_pkg::LEN_W-1:0];
				nxt.q[k]   = {up_data.q[k][dtpm_pkg::Q_W-2:0], 1'b0};
			end
			nxt.num[k] = {up_data.num[k][dtpm_pkg::Q_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule
`default_nettype wire

### rtl/direction_to_pose_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle; the whole pipeline stalls only while a result waits.
// Most of the length comes from two 32-cell square root chains and two 31-cell divider chains.
// Reset: arst_n clears all valid bits and sets mode_q to 0; payload is not reset.
`include "direction_to_pose_matrix_defines.svh"
module direction_to_pose_matrix (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire dtpm_pkg::in_item_t in_req,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dtpm_pkg::out_item_t     out_res
);

	localparam int SQ = dtpm_pkg::SQ_STEPS;
	localparam int DV = dtpm_pkg::DIV_STEPS;

	logic en;
	logic mode_q;

	// stage 1: direction and magnitudes
	logic                     v_s1;
	logic [2:0][31:0]         mag_s1;
	logic [2:0]               neg_s1;
	dtpm_pkg::coord_t [2:0]   tip_s1;
	// stage 2: largest magnitude
	logic                     v_s2;
	logic [2:0][31:0]         mag_s2;
	logic [2:0]               neg_s2;
	dtpm_pkg::coord_t [2:0]   tip_s2;
	logic [31:0]              mx_s2;
	// stage 3: leading one
	logic                     v_s3;
	logic [2:0][31:0]         mag_s3;
	logic [2:0]               neg_s3;
	dtpm_pkg::coord_t [2:0]   tip_s3;
	logic [4:0]               pos_s3;
	logic                     zero_s3;
	// stage 4: scaled magnitudes
	logic                     v_s4;
	logic [2:0][29:0]         m_s4;
	logic [2:0]               neg_s4;
	dtpm_pkg::coord_t [2:0]   tip_s4;
	logic                     zero_s4;
	// stage 5: squares
	logic                     v_s5;
	logic [2:0][59:0]         sq_s5;
	logic [2:0][29:0]         m_s5;
	logic [2:0]               neg_s5;
	dtpm_pkg::coord_t [2:0]   tip_s5;
	logic                     zero_s5;

	logic                     sqa_v [0:SQ];
	dtpm_pkg::sq_t            sqa_d [0:SQ];
	logic                     dva_v [0:DV];
	dtpm_pkg::dv_t            dva_d [0:DV];
	logic                     sqb_v [0:SQ];
	dtpm_pkg::sq_t            sqb_d [0:SQ];
	logic                     dvb_v [0:DV];
	dtpm_pkg::dv_t            dvb_d [0:DV];

	// stage 8: unit normal
	logic                     v_s8;
	dtpm_pkg::ctx_t           ctx_s8;
	// stage 9: first-axis magnitudes
	logic                     v_s9;
	logic [30:0]              ax_s9;
	logic [30:0]              az_s9;
	dtpm_pkg::ctx_t           ctx_s9;
	// stage 10: squares
	logic                     v_s10;
	logic [60:0]              sqx_s10;
	logic [60:0]              sqz_s10;
	dtpm_pkg::ctx_t           ctx_s10;
	// stage 13: first axis
	logic                     v_s13;
	dtpm_pkg::ctx_t           ctx_s13;
	dtpm_pkg::axis_t          t0_s13;
	dtpm_pkg::axis_t          t2_s13;
	// stage 14: products
	logic                     v_s14;
	dtpm_pkg::ctx_t           ctx_s14;
	dtpm_pkg::axis_t          t0_s14;
	dtpm_pkg::axis_t          t2_s14;
	logic signed [63:0]       p_s14 [0:3];
	// stage 15: cross differences
	logic                     v_s15;
	dtpm_pkg::ctx_t           ctx_s15;
	dtpm_pkg::axis_t          t0_s15;
	dtpm_pkg::axis_t          t2_s15;
	logic signed [63:0]       e_s15 [0:2];

	logic                     out_valid_q;
	dtpm_pkg::out_item_t      out_res_q;

	// Global advance: move unless the finished result is still waiting
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Q3.60 to Q1.30, half away from zero, saturated
	function automatic dtpm_pkg::axis_t rnd30(input logic signed [63:0] v);
		logic [63:0] m;
		logic [33:0] q;
		logic        neg;
		dtpm_pkg::axis_t res;
		neg = v[63];
		m   = neg ? (64'd0 - 64'(v)) : 64'(v);
		q   = 34'((m + (64'd1 << 29)) >> 30);
		if (!neg) begin
			res = (q > 34'h7FFF_FFFF) ? dtpm_pkg::axis_t'(32'h7FFF_FFFF) : dtpm_pkg::axis_t'(q[31:0]);
		end else begin
			res = (q > 34'h8000_0000) ? dtpm_pkg::axis_t'(32'h8000_0000)
				: dtpm_pkg::axis_t'(32'd0 - q[31:0]);
		end
		return res;
	endfunction

	// stage 1
	logic [2:0][31:0]       d_c;
	logic signed [32:0]     diff_c;
	dtpm_pkg::coord_t [2:0] tip_c;
	dtpm_pkg::coord_t [2:0] aux_c;

	always_comb begin
		tip_c  = {in_req.tip_z, in_req.tip_y, in_req.tip_x};
		aux_c  = {in_req.aux_z, in_req.aux_y, in_req.aux_x};
		diff_c = '0;
		for (int i = 0; i < 3; i++) begin
			diff_c = {tip_c[i][31], tip_c[i]} - {aux_c[i][31], aux_c[i]};
			if (mode_q) begin
				d_c[i] = aux_c[i];
			end else if (diff_c[32] != diff_c[31]) begin
				d_c[i] = diff_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				d_c[i] = diff_c[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Front stages: direction, scale the largest magnitude to [2^29, 2^30), squares
	logic [4:0] pos_c;
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (mx_s2[i]) begin
				pos_c = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= d_c[i][31] ? (32'd0 - d_c[i]) : d_c[i];
			end
			neg_s1 <= {d_c[2][31], d_c[1][31], d_c[0][31]};
			tip_s1 <= tip_c;

			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			tip_s2 <= tip_s1;
			mx_s2  <= (mag_s1[0] > mag_s1[1])
				? ((mag_s1[0] > mag_s1[2]) ? mag_s1[0] : mag_s1[2])
				: ((mag_s1[1] > mag_s1[2]) ? mag_s1[1] : mag_s1[2]);

			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			tip_s3  <= tip_s2;
			pos_s3  <= pos_c;
			zero_s3 <= (mx_s2 == '0);

			for (int i = 0; i < 3; i++) begin
				if (pos_s3 >= 5'd30) begin
					m_s4[i] <= 30'(mag_s3[i] >> (pos_s3 - 5'd29));
				end else begin
					m_s4[i] <= 30'(mag_s3[i] << (5'd29 - pos_s3));
				end
			end
			neg_s4  <= neg_s3;
			tip_s4  <= tip_s3;
			zero_s4 <= zero_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= 60'(m_s4[i]) * 60'(m_s4[i]);
			end
			m_s5    <= m_s4;
			neg_s5  <= neg_s4;
			tip_s5  <= tip_s4;
			zero_s5 <= zero_s4;
		end
	end

	// stage 6: sum into first root chain; magnitudes ride in the normal slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqa_v[0] <= 1'b0;
		end else if (en) begin
			sqa_v[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_d[0].v         <= dtpm_pkg::SQ_W'(sq_s5[0]) + dtpm_pkg::SQ_W'(sq_s5[1])
				+ dtpm_pkg::SQ_W'(sq_s5[2]);
			sqa_d[0].r         <= '0;
			sqa_d[0].b         <= dtpm_pkg::SQ_W'(1) << 62;
			sqa_d[0].ctx.tip_x <= tip_s5[0];
			sqa_d[0].ctx.tip_y <= tip_s5[1];
			sqa_d[0].ctx.tip_z <= tip_s5[2];
			sqa_d[0].ctx.nx    <= dtpm_pkg::axis_t'({2'b00, m_s5[0]});
			sqa_d[0].ctx.ny    <= dtpm_pkg::axis_t'({2'b00, m_s5[1]});
			sqa_d[0].ctx.nz    <= dtpm_pkg::axis_t'({2'b00, m_s5[2]});
			sqa_d[0].ctx.neg   <= neg_s5;
			sqa_d[0].ctx.flag  <= zero_s5;
		end
	end

	for (genvar g = 0; g < SQ; g++) begin : g_sqa
		dtpm_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(sqa_v[g]), .up_data(sqa_d[g]),
			.dn_valid(sqa_v[g+1]), .dn_data(sqa_d[g+1])
		);
	end

	// stage 7: divider setup for the normal, (m << 30) + len / 2
	logic [61:0]             npa_c [0:2];
	logic [2:0][29:0]        ma_c;
	logic [dtpm_pkg::LEN_W-1:0] lena_c;
	always_comb begin
		lena_c = sqa_d[SQ].r[dtpm_pkg::LEN_W-1:0];
		ma_c   = {sqa_d[SQ].ctx.nz[29:0], sqa_d[SQ].ctx.ny[29:0], sqa_d[SQ].ctx.nx[29:0]};
		for (int i = 0; i < 3; i++) begin
			npa_c[i] = (62'(ma_c[i]) << 30) + 62'(lena_c >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dva_v[0] <= 1'b0;
		end else if (en) begin
			dva_v[0] <= sqa_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dva_d[0].len <= lena_c;
			for (int i = 0; i < 3; i++) begin
				dva_d[0].rem[i] <= npa_c[i][61:31];
				dva_d[0].num[i] <= npa_c[i][30:0];
				dva_d[0].q[i]   <= '0;
			end
			dva_d[0].ctx <= sqa_d[SQ].ctx;
		end
	end

	for (genvar g = 0; g < DV; g++) begin : g_dva
		dtpm_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(dva_v[g]), .up_data(dva_d[g]),
			.dn_valid(dva_v[g+1]), .dn_data(dva_d[g+1])
		);
	end

	// stage 8 to 11: sign the normal, then build the first-axis root input
	dtpm_pkg::axis_t na_c [0:2];
	dtpm_pkg::ctx_t  ctx8_c;
	dtpm_pkg::ctx_t  ctx9_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			na_c[i] = dva_d[DV].ctx.neg[i]
				? dtpm_pkg::axis_t'(32'd0 - 32'(dva_d[DV].q[i]))
				: dtpm_pkg::axis_t'(32'(dva_d[DV].q[i]));
		end
		ctx8_c      = dva_d[DV].ctx;
		ctx8_c.neg  = '0;
		ctx8_c.flag = 1'b0;
		if (dva_d[DV].ctx.flag) begin
			// zero direction falls back to the z axis
			ctx8_c.nx = '0;
			ctx8_c.ny = '0;
			ctx8_c.nz = dtpm_pkg::ONE_Q30;
		end else begin
			ctx8_c.nx = na_c[0];
			ctx8_c.ny = na_c[1];
			ctx8_c.nz = na_c[2];
		end
		ctx9_c      = ctx_s8;
		// t_x takes the sign of n_z, t_z the opposite sign of n_x
		ctx9_c.neg  = {(ctx_s8.nx > 0), 1'b0, ctx_s8.nz[31]};
		ctx9_c.flag = (ctx_s8.ny < dtpm_pkg::ONE_Q30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0; sqb_v[0] <= 1'b0;
		end else if (en) begin
			v_s8     <= dva_v[DV];
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			sqb_v[0] <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8 <= ctx8_c;

			ax_s9  <= ctx_s8.nz[31] ? 31'(32'd0 - ctx_s8.nz) : 31'(ctx_s8.nz);
			az_s9  <= ctx_s8.nx[31] ? 31'(32'd0 - ctx_s8.nx) : 31'(ctx_s8.nx);
			ctx_s9 <= ctx9_c;

			sqx_s10 <= 61'(ax_s9) * 61'(ax_s9);
			sqz_s10 <= 61'(az_s9) * 61'(az_s9);
			ctx_s10 <= ctx_s9;

			sqb_d[0].v   <= dtpm_pkg::SQ_W'(sqx_s10) + dtpm_pkg::SQ_W'(sqz_s10);
			sqb_d[0].r   <= '0;
			sqb_d[0].b   <= dtpm_pkg::SQ_W'(1) << 62;
			sqb_d[0].ctx <= ctx_s10;
		end
	end

	for (genvar g = 0; g < SQ; g++) begin : g_sqb
		dtpm_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(sqb_v[g]), .up_data(sqb_d[g]),
			.dn_valid(sqb_v[g+1]), .dn_data(sqb_d[g+1])
		);
	end

	// stage 12: divider setup for the first axis
	logic [61:0]                npb_c [0:2];
	logic [30:0]                mb_c [0:2];
	logic [dtpm_pkg::LEN_W-1:0] lenb_c;
	dtpm_pkg::ctx_t             ctxb_c;
	always_comb begin
		lenb_c  = sqb_d[SQ].r[dtpm_pkg::LEN_W-1:0];
		mb_c[0] = sqb_d[SQ].ctx.nz[31] ? 31'(32'd0 - sqb_d[SQ].ctx.nz) : 31'(sqb_d[SQ].ctx.nz);
		mb_c[1] = '0;
		mb_c[2] = sqb_d[SQ].ctx.nx[31] ? 31'(32'd0 - sqb_d[SQ].ctx.nx) : 31'(sqb_d[SQ].ctx.nx);
		for (int i = 0; i < 3; i++) begin
			npb_c[i] = (62'(mb_c[i]) << 30) + 62'(lenb_c >> 1);
		end
		ctxb_c      = sqb_d[SQ].ctx;
		ctxb_c.flag = sqb_d[SQ].ctx.flag && (lenb_c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvb_v[0] <= 1'b0;
		end else if (en) begin
			dvb_v[0] <= sqb_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvb_d[0].len <= lenb_c;
			for (int i = 0; i < 3; i++) begin
				dvb_d[0].rem[i] <= npb_c[i][61:31];
				dvb_d[0].num[i] <= npb_c[i][30:0];
				dvb_d[0].q[i]   <= '0;
			end
			dvb_d[0].ctx <= ctxb_c;
		end
	end

	for (genvar g = 0; g < DV; g++) begin : g_dvb
		dtpm_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(dvb_v[g]), .up_data(dvb_d[g]),
			.dn_valid(dvb_v[g+1]), .dn_data(dvb_d[g+1])
		);
	end

	// stage 13 to 15 and output: first axis, then s = n x t with t_y zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0; out_valid_q <= 1'b0;
		end else if (en) begin
			v_s13       <= dvb_v[DV];
			v_s14       <= v_s13;
			v_s15       <= v_s14;
			out_valid_q <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s13 <= dvb_d[DV].ctx;
			if (dvb_d[DV].ctx.flag) begin
				t0_s13 <= dvb_d[DV].ctx.neg[0]
					? dtpm_pkg::axis_t'(32'd0 - 32'(dvb_d[DV].q[0]))
					: dtpm_pkg::axis_t'(32'(dvb_d[DV].q[0]));
				t2_s13 <= dvb_d[DV].ctx.neg[2]
					? dtpm_pkg::axis_t'(32'd0 - 32'(dvb_d[DV].q[2]))
					: dtpm_pkg::axis_t'(32'(dvb_d[DV].q[2]));
			end else begin
				t0_s13 <= dtpm_pkg::ONE_Q30;
				t2_s13 <= '0;
			end

			ctx_s14  <= ctx_s13;
			t0_s14   <= t0_s13;
			t2_s14   <= t2_s13;
			p_s14[0] <= 64'(ctx_s13.ny) * 64'(t2_s13);
			p_s14[1] <= 64'(ctx_s13.nz) * 64'(t0_s13);
			p_s14[2] <= 64'(ctx_s13.nx) * 64'(t2_s13);
			p_s14[3] <= 64'(ctx_s13.ny) * 64'(t0_s13);

			ctx_s15  <= ctx_s14;
			t0_s15   <= t0_s14;
			t2_s15   <= t2_s14;
			e_s15[0] <= p_s14[0];
			e_s15[1] <= p_s14[1] - p_s14[2];
			e_s15[2] <= 64'sd0 - p_s14[3];

			out_res_q.first_axis_x  <= t0_s15;
			out_res_q.first_axis_y  <= '0;
			out_res_q.first_axis_z  <= t2_s15;
			out_res_q.second_axis_x <= rnd30(e_s15[0]);
			out_res_q.second_axis_y <= rnd30(e_s15[1]);
			out_res_q.second_axis_z <= rnd30(e_s15[2]);
			out_res_q.normal_x      <= ctx_s15.nx;
			out_res_q.normal_y      <= ctx_s15.ny;
			out_res_q.normal_z      <= ctx_s15.nz;
			out_res_q.pos_x         <= ctx_s15.tip_x;
			out_res_q.pos_y         <= ctx_s15.tip_y;
			out_res_q.pos_z         <= ctx_s15.tip_z;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`DTPM_ASSERT_IMPL(a_first_y_zero, out_valid, out_res.first_axis_y == '0, "first axis y not zero")
	`DTPM_ASSERT_IMPL(a_normal_y_unit, out_valid, out_res.normal_y <= dtpm_pkg::ONE_Q30, "normal y above one")
	`DTPM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "waiting result dropped")

endmodule
`default_nettype wire
